[sv/xml_entity_decode_utf8_defines.svh]
// Assertion macros shared by the decoder's checker.
`ifndef XML_ENTITY_DECODE_UTF8_DEFINES_SVH
`define XML_ENTITY_DECODE_UTF8_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define XED_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define XED_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/xed_pkg.sv]
// Types, constants and UTF-8 helpers of the XML entity decoder.
`default_nettype none

package xed_pkg;

	typedef enum logic [2:0] {
		MODE_PLAIN,
		MODE_NAME,
		MODE_NUM_START,
		MODE_NUM,
		MODE_ERROR
	} mode_t;

	localparam int unsigned CODE_W = 21;

	localparam logic [CODE_W-1:0] CODE_MAX   = 21'h10ffff;
	localparam logic [CODE_W-1:0] CODE_BMP_LO = 21'h00d7ff;
	localparam logic [CODE_W-1:0] CODE_BMP_HI = 21'h00e000;
	localparam logic [CODE_W-1:0] CODE_BMP_END = 21'h00fffd;
	localparam logic [CODE_W-1:0] CODE_SUPP  = 21'h010000;
	localparam logic [CODE_W-1:0] CODE_TAB   = 21'h000009;
	localparam logic [CODE_W-1:0] CODE_LF    = 21'h00000a;
	localparam logic [CODE_W-1:0] CODE_CR    = 21'h00000d;
	localparam logic [CODE_W-1:0] CODE_SPACE = 21'h000020;
	localparam logic [CODE_W-1:0] CODE_1B_MAX = 21'h00007f;
	localparam logic [CODE_W-1:0] CODE_2B_MAX = 21'h0007ff;
	localparam logic [CODE_W-1:0] CODE_3B_MAX = 21'h00ffff;

	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_SEMI = 8'h3b;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_X_LO = 8'h78;
	localparam logic [7:0] CH_X_UP = 8'h58;
	localparam logic [7:0] CH_LT   = 8'h3c;
	localparam logic [7:0] CH_GT   = 8'h3e;
	localparam logic [7:0] CH_QUOT = 8'h22;
	localparam logic [7:0] CH_APOS = 8'h27;

	localparam logic [31:0] NAME_LT   = 32'h0000_6c74;
	localparam logic [31:0] NAME_GT   = 32'h0000_6774;
	localparam logic [31:0] NAME_AMP  = 32'h0061_6d70;
	localparam logic [31:0] NAME_QUOT = 32'h7175_6f74;
	localparam logic [31:0] NAME_APOS = 32'h6170_6f73;

	// One queued command: nbytes output bytes built from code, or a bare
	// end marker when nbytes is zero.
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [2:0]        nbytes;
		logic              last;
		logic              status;
	} cmd_t;

	function automatic logic code_ok(input logic [CODE_W-1:0] v);
		return v == CODE_TAB || v == CODE_LF || v == CODE_CR ||
			(v >= CODE_SPACE && v <= CODE_BMP_LO) ||
			(v >= CODE_BMP_HI && v <= CODE_BMP_END) ||
			(v >= CODE_SUPP && v <= CODE_MAX);
	endfunction

	function automatic logic [2:0] utf8_len(input logic [CODE_W-1:0] v);
		logic [2:0] n;
		if (v <= CODE_1B_MAX) begin
			n = 3'd1;
		end else if (v <= CODE_2B_MAX) begin
			n = 3'd2;
		end else if (v <= CODE_3B_MAX) begin
			n = 3'd3;
		end else begin
			n = 3'd4;
		end
		return n;
	endfunction

	// Byte idx of an nbytes-long sequence; a one-byte command passes code[7:0].
	function automatic logic [7:0] utf8_byte(input logic [CODE_W-1:0] v,
			input logic [2:0] nbytes, input logic [1:0] idx);
		logic [7:0] b;
		b = 8'h00;
		case (nbytes)
			3'd1: begin
				b = v[7:0];
			end
			3'd2: begin
				case (idx)
					2'd0: b = {3'b110, v[10:6]};
					default: b = {2'b10, v[5:0]};
				endcase
			end
			3'd3: begin
				case (idx)
					2'd0: b = {4'b1110, v[15:12]};
					2'd1: b = {2'b10, v[11:6]};
					default: b = {2'b10, v[5:0]};
				endcase
			end
			3'd4: begin
				case (idx)
					2'd0: b = {5'b11110, v[20:18]};
					2'd1: b = {2'b10, v[17:12]};
					2'd2: b = {2'b10, v[11:6]};
					default: b = {2'b10, v[5:0]};
				endcase
			end
			default: begin
				b = 8'h00;
			end
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

[sv/xed_if.sv]
// Valid/ready channel interfaces for text input and decoded output.
`default_nettype none

interface xed_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       has_byte;
	logic       end_of_text;

	modport source(output valid, text_byte, has_byte, end_of_text, input ready);
	modport sink(input valid, text_byte, has_byte, end_of_text, output ready);
endinterface

interface xed_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       last_of_text;
	logic       decode_status;

	modport source(output valid, out_byte, byte_valid, last_of_text, decode_status,
		input ready);
	modport sink(input valid, out_byte, byte_valid, last_of_text, decode_status,
		output ready);
endinterface

`default_nettype wire

[sv/xml_entity_decode_utf8.sv]
// Top level of the XML entity and character reference decoder.
// Usage:
//   text carries one raw byte per transaction (has_byte) and marks the end of
//   a text with end_of_text; a transaction with neither does nothing.
//   decoded returns bytes in order; entities become one byte, numeric
//   references become 1 to 4 UTF-8 bytes written when the ';' arrives.
//   The final result of a text has last_of_text set; decode_status 1 there
//   means a malformed reference, and the bytes already taken must be dropped.
//   A bare end marker with nothing to write yields one result, byte_valid 0.
// Timing:
//   A byte passes through the command queue and the output register to decoded.
//   Text is taken one byte per cycle while the queue has room; a numeric
//   reference holding n bytes leaves the single output register as n results.
//   A command queue of QUEUE_DEPTH entries lets the input run ahead.
// Reset and stall:
//   arst_n clears the parser to plain text and empties queue and output.
//   While decoded stalls, the output holds; text stalls once the queue fills.
`default_nettype none

module xml_entity_decode_utf8 #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	xed_in_if.sink    text,
	xed_out_if.source decoded
);
	import xed_pkg::*;

	logic push_valid, push_ready, pop, head_valid;
	cmd_t push_cmd, head;

	xed_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text),
		.push_ready(push_ready),
		.push_valid(push_valid),
		.push_cmd  (push_cmd)
	);

	xed_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_cmd  (push_cmd),
		.push_ready(push_ready),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	xed_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.decoded   (decoded)
	);

endmodule

`default_nettype wire

[sv/xed_front.sv]
// Front end: parses text bytes and queues output commands.
`default_nettype none

module xed_front (
	input  wire logic   clk,
	input  wire logic   arst_n,
	xed_in_if.sink      text,
	input  wire logic   push_ready,
	output logic        push_valid,
	output xed_pkg::cmd_t push_cmd
);
	import xed_pkg::*;

	mode_t             mode_q, mode_tb;
	logic [31:0]       name_q, name_tb;
	logic [2:0]        count_q, count_tb;
	logic [CODE_W-1:0] code_q, code_tb;
	logic              big_q, big_tb;
	logic              hex_q, hex_tb;
	logic              seen_q, seen_tb;

	logic       acc;
	logic [7:0] b;
	logic       is_dec, is_lhex, is_uhex, is_digit;
	logic [3:0] digit;
	logic [24:0] mul, nv;
	logic       over;
	logic       name_hit;
	logic [7:0] name_char;
	logic       num_ok;
	logic [2:0] emit_n;
	logic [CODE_W-1:0] emit_code;

	assign text.ready = push_ready;
	assign acc = text.valid && push_ready;
	assign b = text.text_byte;

	// Classify the byte, prepare the next accumulated value and match the entity name.
	always_comb begin
		is_dec  = b >= 8'h30 && b <= 8'h39;
		is_lhex = hex_q && b >= 8'h61 && b <= 8'h66;
		is_uhex = hex_q && b >= 8'h41 && b <= 8'h46;
		is_digit = is_dec || is_lhex || is_uhex;
		digit = is_dec ? b[3:0] : b[3:0] + 4'd9;
		mul = hex_q ? {code_q, 4'b0000} : ({1'b0, code_q, 3'b000} + {3'b000, code_q, 1'b0});
		nv = mul + {21'd0, digit};
		over = nv > {4'd0, CODE_MAX};
		name_hit = 1'b1;
		name_char = 8'h00;
		if (count_q == 3'd2 && name_q == NAME_LT) begin
			name_char = CH_LT;
		end else if (count_q == 3'd2 && name_q == NAME_GT) begin
			name_char = CH_GT;
		end else if (count_q == 3'd3 && name_q == NAME_AMP) begin
			name_char = CH_AMP;
		end else if (count_q == 3'd4 && name_q == NAME_QUOT) begin
			name_char = CH_QUOT;
		end else if (count_q == 3'd4 && name_q == NAME_APOS) begin
			name_char = CH_APOS;
		end else begin
			name_hit = 1'b0;
		end
		num_ok = seen_q && !big_q && code_ok(code_q);
	end

	// Next state after the byte, before the end marker is applied.
	always_comb begin
		mode_tb = mode_q;
		name_tb = name_q;
		count_tb = count_q;
		code_tb = code_q;
		big_tb = big_q;
		hex_tb = hex_q;
		seen_tb = seen_q;
		if (text.has_byte) begin
			case (mode_q)
				MODE_PLAIN: begin
					if (b == CH_AMP) begin
						mode_tb = MODE_NAME;
						name_tb = '0;
						count_tb = '0;
						code_tb = '0;
						big_tb = 1'b0;
						hex_tb = 1'b0;
						seen_tb = 1'b0;
					end
				end
				MODE_NAME: begin
					if (b == CH_SEMI) begin
						mode_tb = name_hit ? MODE_PLAIN : MODE_ERROR;
						if (name_hit) begin
							name_tb = '0;
							count_tb = '0;
						end
					end else if (count_q == 3'd0 && b == CH_HASH) begin
						mode_tb = MODE_NUM_START;
					end else if (count_q >= 3'd4) begin
						mode_tb = MODE_ERROR;
					end else begin
						name_tb = {name_q[23:0], b};
						count_tb = count_q + 3'd1;
					end
				end
				MODE_NUM_START, MODE_NUM: begin
					if (mode_q == MODE_NUM && b == CH_SEMI) begin
						mode_tb = num_ok ? MODE_PLAIN : MODE_ERROR;
						if (num_ok) begin
							code_tb = '0;
							big_tb = 1'b0;
							hex_tb = 1'b0;
							seen_tb = 1'b0;
						end
					end else if (mode_q == MODE_NUM_START && (b == CH_X_LO || b == CH_X_UP)) begin
						hex_tb = 1'b1;
						mode_tb = MODE_NUM;
					end else if (is_digit) begin
						seen_tb = 1'b1;
						mode_tb = MODE_NUM;
						if (!big_q) begin
							if (over) begin
								big_tb = 1'b1;
							end else begin
								code_tb = nv[CODE_W-1:0];
							end
						end
					end else begin
						mode_tb = MODE_ERROR;
					end
				end
				default: begin
					mode_tb = MODE_ERROR;
				end
			endcase
		end
	end

	// Command for the back end: bytes to write and end-of-text status.
	always_comb begin
		emit_n = 3'd0;
		emit_code = '0;
		if (text.has_byte) begin
			case (mode_q)
				MODE_PLAIN: begin
					if (b != CH_AMP) begin
						emit_n = 3'd1;
						emit_code = {13'd0, b};
					end
				end
				MODE_NAME: begin
					if (b == CH_SEMI && name_hit) begin
						emit_n = 3'd1;
						emit_code = {13'd0, name_char};
					end
				end
				MODE_NUM: begin
					if (b == CH_SEMI && num_ok) begin
						emit_n = utf8_len(code_q);
						emit_code = code_q;
					end
				end
				default: begin
					emit_n = 3'd0;
				end
			endcase
		end
		push_valid = acc && (emit_n != 3'd0 || text.end_of_text);
		push_cmd.code = emit_code;
		push_cmd.nbytes = emit_n;
		push_cmd.last = text.end_of_text;
		push_cmd.status = text.end_of_text && mode_tb != MODE_PLAIN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			name_q <= '0;
			count_q <= '0;
			code_q <= '0;
			big_q <= 1'b0;
			hex_q <= 1'b0;
			seen_q <= 1'b0;
		end else if (acc) begin
			if (text.end_of_text) begin
				mode_q <= MODE_PLAIN;
				name_q <= '0;
				count_q <= '0;
				code_q <= '0;
				big_q <= 1'b0;
				hex_q <= 1'b0;
				seen_q <= 1'b0;
			end else begin
				mode_q <= mode_tb;
				name_q <= name_tb;
				count_q <= count_tb;
				code_q <= code_tb;
				big_q <= big_tb;
				hex_q <= hex_tb;
				seen_q <= seen_tb;
			end
		end
	end

endmodule

`default_nettype wire

[sv/xed_queue.sv]
// Command queue between parser and byte writer.
`default_nettype none

module xed_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	input  wire xed_pkg::cmd_t  push_cmd,
	output logic                push_ready,
	input  wire logic           pop,
	output logic                head_valid,
	output xed_pkg::cmd_t       head
);
	import xed_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign push_ready = cnt_q != CNT_W'(DEPTH);
	assign head_valid = cnt_q != '0;
	assign head = mem_q[rd_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

[sv/xed_back.sv]
// Back end: expands queued commands into output bytes.
`default_nettype none

module xed_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          head_valid,
	input  wire xed_pkg::cmd_t head,
	output logic               pop,
	xed_out_if.source          decoded
);
	import xed_pkg::*;

	logic [1:0] idx_q;
	logic       vld_q;
	logic [7:0] byte_q;
	logic       bval_q, last_q, stat_q;
	logic       load, final_byte;

	assign load = head_valid && (!vld_q || decoded.ready);
	assign final_byte = head.nbytes == 3'd0 || {1'b0, idx_q} == head.nbytes - 3'd1;
	assign pop = load && final_byte;

	assign decoded.valid = vld_q;
	assign decoded.out_byte = byte_q;
	assign decoded.byte_valid = bval_q;
	assign decoded.last_of_text = last_q;
	assign decoded.decode_status = stat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			vld_q <= 1'b1;
			idx_q <= final_byte ? 2'd0 : idx_q + 2'd1;
		end else if (decoded.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= utf8_byte(head.code, head.nbytes, idx_q);
			bval_q <= head.nbytes != 3'd0;
			last_q <= head.last && final_byte;
			stat_q <= head.status && final_byte;
		end
	end

endmodule

`default_nettype wire

[sv/xed_checker.sv]
// Port-level checker for the decoder, bound to the top level.
`default_nettype none
`include "xml_entity_decode_utf8_defines.svh"

module xed_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       byte_valid,
	input wire logic       last_of_text,
	input wire logic       decode_status
);

	`XED_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(byte_valid) && $stable(last_of_text) && $stable(decode_status), "decoded result changed while stalled")

	`XED_ASSERT_NOW(a_empty_is_last, clk, arst_n, out_valid && !byte_valid, last_of_text, "result without a byte is not the final one")

	`XED_ASSERT_NOW(a_status_on_last, clk, arst_n, out_valid && decode_status, last_of_text, "error status outside the final result")

	`XED_ASSERT_NOW(a_empty_zero, clk, arst_n, out_valid && !byte_valid, out_byte == 8'h00, "result without a byte carries data")

endmodule

bind xml_entity_decode_utf8 xed_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (decoded.valid),
	.out_ready    (decoded.ready),
	.out_byte     (decoded.out_byte),
	.byte_valid   (decoded.byte_valid),
	.last_of_text (decoded.last_of_text),
	.decode_status(decoded.decode_status)
);

`default_nettype wire
